@@ design/jpeg_marker_segment_scanner_top_macros.svh @@
// Assertion macros for the marker segment scanner.
`ifndef JPEG_MARKER_SEGMENT_SCANNER_TOP_MACROS_SVH
`define JPEG_MARKER_SEGMENT_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold in the same cycle as the trigger.
`define JMSS_ASSERT_NOW(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("jmss check failed");
// Condition must hold in the cycle after the trigger.
`define JMSS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("jmss check failed");
`else
`define JMSS_ASSERT_NOW(label, clk, rst_n, trig, cond)
`define JMSS_ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif

`endif

@@ design/jmss_pkg.sv @@
`timescale 1ns / 1ps
package jmss_pkg;

  localparam int SECTION_LIMIT_DEF = 20;

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] MRK_SOI   = 8'hD8;
  localparam logic [7:0] MRK_EOI   = 8'hD9;
  localparam logic [7:0] MRK_SOS   = 8'hDA;
  localparam logic [7:0] MRK_APP0  = 8'hE0;
  localparam logic [7:0] MRK_APP1  = 8'hE1;
  localparam logic [7:0] MRK_COM   = 8'hFE;
  localparam logic [7:0] MRK_SOF0  = 8'hC0;
  localparam logic [7:0] MRK_DHT   = 8'hC4;
  localparam logic [7:0] MRK_JPG   = 8'hC8;
  localparam logic [7:0] MRK_DAC   = 8'hCC;

  localparam logic [2:0]  FILL_MAX     = 3'd6;
  localparam logic [15:0] LEN_MIN      = 16'd2;
  localparam logic [15:0] LEN_APP1_TAG = 16'd6;
  localparam logic [15:0] LEN_FRAME    = 16'd8;
  localparam logic [7:0]  NCOMP_COLOR  = 8'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SOI    = 3'd1,
    ST_TOO_MANY  = 3'd2,
    ST_PADDING   = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_EARLY_END = 3'd5
  } status_t;

  // Bytes of the "Exif" tag at the head of an APP1 payload.
  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h45;
      2'd1:    b = 8'h78;
      2'd2:    b = 8'h69;
      default: b = 8'h66;
    endcase
    return b;
  endfunction

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m[7:4] == MRK_SOF0[7:4]) && (m != MRK_DHT) && (m != MRK_JPG) && (m != MRK_DAC);
  endfunction

endpackage

@@ design/jpeg_marker_segment_scanner_top.sv @@
`timescale 1ns / 1ps
// Output: the result is registered and appears in the output register in the cycle after the byte that ends parsing.
// Throughput: one byte per cycle while in_stall is low; the parse state updates in a single pass per byte.
// Input stalls only while the output register holds a result that out_stall keeps back.
// Reset: synchronous active-low rst_n clears the parse state and empties the output register.
// in_first_byte restarts the parse with the same byte handled as the first of a new file.
`include "jpeg_marker_segment_scanner_top_macros.svh"

module jpeg_marker_segment_scanner_top
  import jmss_pkg::*;
#(
  parameter int SECTION_LIMIT = SECTION_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_image_height,
  output logic [15:0] out_image_width,
  output logic        out_is_color,
  output logic [7:0]  out_frame_kind,
  output logic [5:0]  out_sections_kept,
  output logic        out_comment_seen,
  output logic        out_exif_seen
);

  typedef enum logic [2:0] {
    PH_SOI_A, PH_SOI_B, PH_MARK, PH_LEN_HI, PH_LEN_LO, PH_BODY
  } phase_t;

  localparam logic [5:0] LIMIT = 6'(SECTION_LIMIT);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [7:0]  marker_r, marker_nxt;
  logic [15:0] seg_len_r, seg_len_nxt;
  logic [15:0] pidx_r, pidx_nxt;
  logic [5:0]  kept_r, kept_nxt;
  logic        tag_r, tag_nxt;
  logic [15:0] held_h_r, held_h_nxt;
  logic [15:0] held_w_r, held_w_nxt;
  logic        held_c_r, held_c_nxt;
  logic [7:0]  held_k_r, held_k_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic        fin_r, fin_nxt;
  logic [15:0] stg_h_r, stg_h_nxt;
  logic [15:0] stg_w_r, stg_w_nxt;
  logic        stg_c_r, stg_c_nxt;

  logic        in_acc;
  logic        emit;
  status_t     st;
  logic        close_seg;
  logic        keep;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_h_r, out_w_r;
  logic        out_c_r;
  logic [7:0]  out_k_r;
  logic [5:0]  out_kept_r;
  logic [1:0]  out_flags_r;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    marker_nxt = marker_r;
    seg_len_nxt = seg_len_r;
    pidx_nxt   = pidx_r;
    kept_nxt   = kept_r;
    tag_nxt    = tag_r;
    held_h_nxt = held_h_r;
    held_w_nxt = held_w_r;
    held_c_nxt = held_c_r;
    held_k_nxt = held_k_r;
    flags_nxt  = flags_r;
    fin_nxt    = fin_r;
    stg_h_nxt  = stg_h_r;
    stg_w_nxt  = stg_w_r;
    stg_c_nxt  = stg_c_r;
    emit       = 1'b0;
    st         = ST_OK;
    close_seg  = 1'b0;
    keep       = 1'b1;

    if (in_acc) begin
      if (in_first_byte) begin
        phase_nxt  = PH_SOI_A;
        fill_nxt   = '0;
        marker_nxt = '0;
        seg_len_nxt = '0;
        pidx_nxt   = '0;
        kept_nxt   = '0;
        tag_nxt    = 1'b1;
        held_h_nxt = '0;
        held_w_nxt = '0;
        held_c_nxt = 1'b0;
        held_k_nxt = '0;
        flags_nxt  = '0;
        fin_nxt    = 1'b0;
        stg_h_nxt  = '0;
        stg_w_nxt  = '0;
        stg_c_nxt  = 1'b0;
      end
      if (!fin_nxt) begin
        if (in_end_of_stream) begin
          emit = 1'b1;
          st = (phase_nxt == PH_SOI_A || phase_nxt == PH_SOI_B) ? ST_NO_SOI : ST_EARLY_END;
        end else begin
          unique case (phase_nxt)
            PH_SOI_A: begin
              if (in_data_byte != BYTE_FILL) begin
                emit = 1'b1;
                st = ST_NO_SOI;
              end else begin
                phase_nxt = PH_SOI_B;
              end
            end
            PH_SOI_B: begin
              if (in_data_byte != MRK_SOI) begin
                emit = 1'b1;
                st = ST_NO_SOI;
              end else begin
                phase_nxt = PH_MARK;
                fill_nxt = '0;
              end
            end
            PH_MARK: begin
              if (in_data_byte == BYTE_FILL) begin
                if (fill_nxt >= FILL_MAX) begin
                  emit = 1'b1;
                  st = ST_PADDING;
                end else begin
                  fill_nxt = fill_nxt + 3'd1;
                end
              end else begin
                marker_nxt = in_data_byte;
                tag_nxt = 1'b1;
                stg_h_nxt = '0;
                stg_w_nxt = '0;
                stg_c_nxt = 1'b0;
                phase_nxt = PH_LEN_HI;
              end
            end
            PH_LEN_HI: begin
              seg_len_nxt = {in_data_byte, 8'h00};
              phase_nxt = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              seg_len_nxt = {seg_len_nxt[15:8], in_data_byte};
              pidx_nxt = '0;
              if (seg_len_nxt < LEN_MIN) begin
                emit = 1'b1;
                st = ST_BAD_LEN;
              end else if (seg_len_nxt == LEN_MIN) begin
                close_seg = 1'b1;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
            PH_BODY: begin
              if (pidx_nxt < 16'd4 && in_data_byte != tag_byte(pidx_nxt[1:0])) tag_nxt = 1'b0;
              case (pidx_nxt)
                16'd1:   stg_h_nxt = {in_data_byte, 8'h00};
                16'd2:   stg_h_nxt = {stg_h_nxt[15:8], in_data_byte};
                16'd3:   stg_w_nxt = {in_data_byte, 8'h00};
                16'd4:   stg_w_nxt = {stg_w_nxt[15:8], in_data_byte};
                16'd5:   stg_c_nxt = (in_data_byte == NCOMP_COLOR);
                default: ;
              endcase
              if ({1'b0, pidx_nxt} + 17'd3 >= {1'b0, seg_len_nxt}) begin
                close_seg = 1'b1;
              end else begin
                pidx_nxt = pidx_nxt + 16'd1;
              end
            end
            default: ;
          endcase

          if (close_seg) begin
            if (marker_nxt == MRK_SOS) begin
              emit = 1'b1;
              st = ST_OK;
            end else if (marker_nxt == MRK_EOI) begin
              emit = 1'b1;
              st = ST_EARLY_END;
            end else begin
              if (marker_nxt == MRK_COM) begin
                // only the first comment segment counts
                if (flags_nxt[0]) keep = 1'b0;
                else flags_nxt[0] = 1'b1;
              end else if (marker_nxt == MRK_APP0) begin
                keep = 1'b0;
              end else if (marker_nxt == MRK_APP1) begin
                if (tag_nxt && seg_len_nxt >= LEN_APP1_TAG) flags_nxt[1] = 1'b1;
                else keep = 1'b0;
              end else if (is_frame_marker(marker_nxt) && seg_len_nxt >= LEN_FRAME) begin
                held_h_nxt = stg_h_nxt;
                held_w_nxt = stg_w_nxt;
                held_c_nxt = stg_c_nxt;
                held_k_nxt = marker_nxt;
              end
              if (keep) kept_nxt = kept_nxt + 6'd1;
              if (kept_nxt >= LIMIT) begin
                emit = 1'b1;
                st = ST_TOO_MANY;
              end else begin
                phase_nxt = PH_MARK;
                fill_nxt = '0;
              end
            end
          end
        end
        if (emit) fin_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SOI_A;
      fill_r   <= '0;
      marker_r <= '0;
      seg_len_r <= '0;
      pidx_r   <= '0;
      kept_r   <= '0;
      tag_r    <= 1'b1;
      held_h_r <= '0;
      held_w_r <= '0;
      held_c_r <= 1'b0;
      held_k_r <= '0;
      flags_r  <= '0;
      fin_r    <= 1'b0;
      stg_h_r  <= '0;
      stg_w_r  <= '0;
      stg_c_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      marker_r <= marker_nxt;
      seg_len_r <= seg_len_nxt;
      pidx_r   <= pidx_nxt;
      kept_r   <= kept_nxt;
      tag_r    <= tag_nxt;
      held_h_r <= held_h_nxt;
      held_w_r <= held_w_nxt;
      held_c_r <= held_c_nxt;
      held_k_r <= held_k_nxt;
      flags_r  <= flags_nxt;
      fin_r    <= fin_nxt;
      stg_h_r  <= stg_h_nxt;
      stg_w_r  <= stg_w_nxt;
      stg_c_r  <= stg_c_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Load the result register; emit only fires when it is free or draining.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= st;
      out_h_r      <= held_h_nxt;
      out_w_r      <= held_w_nxt;
      out_c_r      <= held_c_nxt;
      out_k_r      <= held_k_nxt;
      out_kept_r   <= kept_nxt;
      out_flags_r  <= flags_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_image_height  = out_h_r;
  assign out_image_width   = out_w_r;
  assign out_is_color      = out_c_r;
  assign out_frame_kind    = out_k_r;
  assign out_sections_kept = out_kept_r;
  assign out_comment_seen  = out_flags_r[0];
  assign out_exif_seen     = out_flags_r[1];

  `JMSS_ASSERT_NEXT(a_emit_sets_done, clk, rst_n, emit, fin_r && out_valid_r)
  `JMSS_ASSERT_NEXT(a_done_holds, clk, rst_n, fin_r && !(in_acc && in_first_byte), fin_r)
  `JMSS_ASSERT_NOW(a_done_quiet, clk, rst_n, fin_r && !(in_acc && in_first_byte), !emit)
  `JMSS_ASSERT_NOW(a_kept_bounded, clk, rst_n, 1'b1, kept_r <= LIMIT)
  `JMSS_ASSERT_NOW(a_body_len, clk, rst_n, phase_r == PH_BODY, seg_len_r > LEN_MIN)
  `JMSS_ASSERT_NOW(a_no_emit_stalled, clk, rst_n, emit, !(out_valid_r && out_stall))

endmodule
